### hw/rtl/faf_pkg.sv
// Shared constants, codes and types of the Fourier angle flattening block.
package faf_pkg;

    localparam int DETECTORS = 16;
    localparam int HARMONICS = 4;
    localparam int MULT_BINS = 4;
    localparam int ZVTX_BINS = 8;
    localparam int ORDERS    = 8;

    localparam int KIND_W  = 2;
    localparam int DET_W   = 4;
    localparam int HAR_W   = 2;
    localparam int MUL_W   = 2;
    localparam int ZV_W    = 3;
    localparam int ORD_W   = 3;
    localparam int COEF_W  = 16;
    localparam int ANG_W   = 16;
    localparam int SET_W   = MUL_W + ZV_W + HAR_W + DET_W;
    localparam int ADDR_W  = SET_W + ORD_W;
    localparam int DEPTH   = DETECTORS * HARMONICS * MULT_BINS * ZVTX_BINS * ORDERS;

    // One correction term is at most 2^32 in magnitude; eight of them fit 36 bits.
    localparam int TERM_W  = 34;
    localparam int ACC_W   = 36;

    localparam logic [KIND_W-1:0] KIND_LOAD_COS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLATTEN  = 2'd2;

    // Radians (Q30 accumulator) to binary angle: round(2^27/pi) then >> 42.
    localparam logic [25:0] RAD_TO_BA = 26'd42722830;
    localparam int          BA_SHIFT  = 42;
    localparam logic [15:0] DIV3_M    = 16'd43691;
    localparam int          DIV3_SH   = 17;

    typedef struct packed {
        logic                     valid;
        logic [ANG_W-1:0]         ang;
        logic [ORD_W-1:0]         k_idx;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] s;
    } t_term_in;

    typedef struct packed {
        logic                     valid;
        logic [ORD_W-1:0]         k_idx;
        logic signed [TERM_W-1:0] term;
    } t_term_out;

endpackage

### hw/rtl/faf_if.sv
// Valid/ready channel interfaces for input items and result words.
interface faf_in_if;
    logic                             valid;
    logic                             ready;
    logic [faf_pkg::KIND_W-1:0]       kind;
    logic [faf_pkg::DET_W-1:0]        detector;
    logic [faf_pkg::HAR_W-1:0]        harmonic;
    logic [faf_pkg::MUL_W-1:0]        mult_bin;
    logic [faf_pkg::ZV_W-1:0]         zvertex_bin;
    logic [faf_pkg::ORD_W-1:0]        order;
    logic signed [faf_pkg::COEF_W-1:0] coefficient;
    logic signed [faf_pkg::ANG_W-1:0]  angle_in;

    modport source(output valid, kind, detector, harmonic, mult_bin, zvertex_bin, order,
                   coefficient, angle_in, input ready);
    modport sink(input valid, kind, detector, harmonic, mult_bin, zvertex_bin, order,
                 coefficient, angle_in, output ready);
endinterface

interface faf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [faf_pkg::ANG_W-1:0]  angle_out;

    modport source(output valid, angle_out, input ready);
    modport sink(input valid, angle_out, output ready);
endinterface

### hw/rtl/faf_term.sv
// Pipelined correction term: table-free sine/cosine, C*sin - S*cos, 2d/k.
module faf_term (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  faf_pkg::t_term_in   i_req,
    output faf_pkg::t_term_out  o_rsp
);

    localparam logic [12:0] P0 = 13'd4569;
    localparam logic [15:0] P1 = 16'd41906;
    localparam logic [16:0] P2 = 17'd102873;
    localparam int          RSH = 22;

    function automatic logic [14:0] fold(input logic [15:0] a);
        logic [14:0] r;
        r = {1'b0, a[13:0]};
        return a[14] ? (15'd16384 - r) : r;
    endfunction

    function automatic logic [22:0] recip(input logic [2:0] o);
        logic [22:0] m;
        unique case (o)
            3'd3:    m = 23'd1398102;
            3'd5:    m = 23'd838861;
            3'd7:    m = 23'd599187;
            default: m = 23'd4194304;
        endcase
        return m;
    endfunction

    logic [11:1] r_v;
    logic [2:0]  r_k [11:1];

    logic [15:0] w_ang_c;
    logic [14:0] r1_xs, r1_xc, r2_xs, r2_xc, r3_xs, r3_xc, r4_xs, r4_xc;
    logic [14:0] r2_x2s, r2_x2c, r3_x2s, r3_x2c;
    logic [15:0] r3_t1s, r3_t1c;
    logic [16:0] r4_t2s, r4_t2c;
    logic        r1_ns, r1_nc, r2_ns, r2_nc, r3_ns, r3_nc, r4_ns, r4_nc;
    logic signed [15:0] r1_c, r1_s, r2_c, r2_s, r3_c, r3_s, r4_c, r4_s, r5_c, r5_s;
    logic signed [15:0] r5_sin, r5_cos;
    logic signed [31:0] r6_p, r6_q;
    logic [32:0] r7_m;
    logic        r7_n, r8_n, r9_n, r10_n;
    logic [2:0]  r7_o, r8_o, r9_o;
    logic [16:0] r8_qh, r9_qh, r10_qh;
    logic [16:0] r8_xh;
    logic [15:0] r8_xl;
    logic [18:0] r9_xlo;
    logic [15:0] r10_ql;
    logic signed [33:0] r11_term;

    logic [29:0] w1_sqs, w1_sqc;
    logic [27:0] w3_ps, w3_pc;
    logic [30:0] w4_ps, w4_pc;
    logic [31:0] w5_ys, w5_yc;
    logic [15:0] w5_ss, w5_sc;
    logic signed [32:0] w7_d;
    logic [31:0] w7_abs;
    logic [32:0] w7_two;
    logic [1:0]  w7_e;
    logic [2:0]  w7_o;
    logic [39:0] w8_p;
    logic [19:0] w9_qo;
    logic [2:0]  w9_r;
    logic [41:0] w10_p;
    logic [32:0] w11_mag;

    assign w_ang_c = i_req.ang + 16'h4000;

    always_comb begin
        w1_sqs = r1_xs * r1_xs;
        w1_sqc = r1_xc * r1_xc;
        w3_ps  = P0 * r2_x2s;
        w3_pc  = P0 * r2_x2c;
        w4_ps  = r3_t1s * r3_x2s;
        w4_pc  = r3_t1c * r3_x2c;
        w5_ys  = r4_t2s * r4_xs;
        w5_yc  = r4_t2c * r4_xc;
        w5_ss  = (w5_ys[31:15] > 17'd32767) ? 16'd32767 : w5_ys[30:15];
        w5_sc  = (w5_yc[31:15] > 17'd32767) ? 16'd32767 : w5_yc[30:15];
        w7_d   = 33'(r6_p) - 33'(r6_q);
        w7_abs = w7_d[32] ? 32'(-w7_d) : 32'(w7_d);
        w7_two = {w7_abs, 1'b0};
        // k = 2^e * odd
        unique case (r_k[6])
            3'd0: begin w7_e = 2'd0; w7_o = 3'd1; end
            3'd1: begin w7_e = 2'd1; w7_o = 3'd1; end
            3'd2: begin w7_e = 2'd0; w7_o = 3'd3; end
            3'd3: begin w7_e = 2'd2; w7_o = 3'd1; end
            3'd4: begin w7_e = 2'd0; w7_o = 3'd5; end
            3'd5: begin w7_e = 2'd1; w7_o = 3'd3; end
            3'd6: begin w7_e = 2'd0; w7_o = 3'd7; end
            default: begin w7_e = 2'd3; w7_o = 3'd1; end
        endcase
        w8_p    = r7_m[32:16] * recip(r7_o);
        w9_qo   = r8_qh * r8_o;
        w9_r    = 3'(20'(r8_xh) - w9_qo);
        w10_p   = r9_xlo * recip(r9_o);
        w11_mag = {r10_qh, 16'd0} + 33'(r10_ql);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[10:1], i_req.valid};
        end
        r_k[1] <= i_req.k_idx;
        for (int i = 2; i <= 11; i++) r_k[i] <= r_k[i-1];

        r1_xs <= fold(i_req.ang);  r1_ns <= i_req.ang[15];
        r1_xc <= fold(w_ang_c);    r1_nc <= w_ang_c[15];
        r1_c  <= i_req.c;          r1_s  <= i_req.s;

        r2_x2s <= w1_sqs[28:14];
        r2_x2c <= w1_sqc[28:14];
        r2_xs <= r1_xs; r2_xc <= r1_xc; r2_ns <= r1_ns; r2_nc <= r1_nc;
        r2_c  <= r1_c;  r2_s  <= r1_s;

        r3_t1s <= P1 - 16'(w3_ps[27:14]);
        r3_t1c <= P1 - 16'(w3_pc[27:14]);
        r3_x2s <= r2_x2s; r3_x2c <= r2_x2c;
        r3_xs <= r2_xs; r3_xc <= r2_xc; r3_ns <= r2_ns; r3_nc <= r2_nc;
        r3_c  <= r2_c;  r3_s  <= r2_s;

        r4_t2s <= P2 - w4_ps[30:14];
        r4_t2c <= P2 - w4_pc[30:14];
        r4_xs <= r3_xs; r4_xc <= r3_xc; r4_ns <= r3_ns; r4_nc <= r3_nc;
        r4_c  <= r3_c;  r4_s  <= r3_s;

        r5_sin <= r4_ns ? -$signed(w5_ss) : $signed(w5_ss);
        r5_cos <= r4_nc ? -$signed(w5_sc) : $signed(w5_sc);
        r5_c   <= r4_c; r5_s <= r4_s;

        r6_p <= r5_c * r5_sin;
        r6_q <= r5_s * r5_cos;

        r7_m <= w7_two >> w7_e;
        r7_n <= w7_d[32];
        r7_o <= w7_o;

        r8_qh <= 17'(w8_p >> RSH);
        r8_xh <= r7_m[32:16];
        r8_xl <= r7_m[15:0];
        r8_n  <= r7_n; r8_o <= r7_o;

        r9_xlo <= {w9_r, r8_xl};
        r9_qh  <= r8_qh; r9_n <= r8_n; r9_o <= r8_o;

        r10_ql <= 16'(w10_p >> RSH);
        r10_qh <= r9_qh; r10_n <= r9_n;

        r11_term <= r10_n ? -$signed({1'b0, w11_mag}) : $signed({1'b0, w11_mag});
    end

    assign o_rsp.valid = r_v[11];
    assign o_rsp.k_idx = r_k[11];
    assign o_rsp.term  = r11_term;

endmodule

### hw/rtl/fourier_angle_flattening_core.sv
// Top level: coefficient memories, load/flatten sequencer and final scaling.
// A flatten item is not accepted until the previous one is done: eight
//   coefficient-pair reads (one order per cycle), the 11-stage term pipeline,
//   scaling, summing and division, and a wait for the output register to be
//   free before the return to idle.
// Load items are accepted back to back in idle. Both memories are swept to zero
//   after reset, one entry per cycle over all 16384 entries, accepting no item.
module fourier_angle_flattening_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    faf_in_if.sink           i_item,
    faf_out_if.source        o_result
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RUN, S_WAIT, S_SCALE, S_SUM, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    // Coefficient memories, one entry per (bin set, order)
    logic signed [faf_pkg::COEF_W-1:0] r_cos_mem [faf_pkg::DEPTH];
    logic signed [faf_pkg::COEF_W-1:0] r_sin_mem [faf_pkg::DEPTH];
    logic signed [faf_pkg::COEF_W-1:0] r_cos_rd, r_sin_rd;

    logic [faf_pkg::ADDR_W-1:0] r_clr_addr;
    logic [faf_pkg::SET_W-1:0]  r_set;
    logic                       r_set_ok;
    logic [faf_pkg::HAR_W-1:0]  r_har;
    logic [faf_pkg::ANG_W-1:0]  r_psi0, r_ang;
    logic [faf_pkg::ORD_W-1:0]  r_k;

    // Read alignment: tags that match the registered memory data
    logic                       r_rd_vld, r_rd_ok;
    logic [faf_pkg::ANG_W-1:0]  r_rd_ang;
    logic [faf_pkg::ORD_W-1:0]  r_rd_k;

    logic signed [faf_pkg::ACC_W-1:0] r_acc;
    logic        r_acc_n;
    logic [42:0] r_ph;
    logic [43:0] r_pl;
    logic [15:0] r_total;
    logic [15:0] r_res;
    logic        r_out_valid;
    logic [15:0] r_out_angle;

    logic                        w_in_acc, w_in_range, w_ord_ok, w_is_load;
    logic                        w_cos_we, w_sin_we;
    logic [faf_pkg::ADDR_W-1:0]  w_wr_addr, w_rd_addr;
    logic [faf_pkg::COEF_W-1:0]  w_wr_data;
    logic [faf_pkg::SET_W-1:0]   w_in_set;
    logic [2:0]                  w_n;
    logic [18:0]                 w_prod;
    logic [34:0]                 w_acc_mag;
    logic [60:0]                 w_sum;
    logic [18:0]                 w_dmag;
    logic [15:0]                 w_delta;
    logic [16:0]                 w_tmag;
    logic [32:0]                 w_t3;
    logic [16:0]                 w_q;
    faf_pkg::t_term_in           w_req;
    faf_pkg::t_term_out          w_rsp;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_in_acc     = i_item.valid && i_item.ready;

    always_comb begin
        w_in_range = (32'(i_item.detector)    < faf_pkg::DETECTORS) &&
                     (32'(i_item.harmonic)    < faf_pkg::HARMONICS) &&
                     (32'(i_item.mult_bin)    < faf_pkg::MULT_BINS) &&
                     (32'(i_item.zvertex_bin) < faf_pkg::ZVTX_BINS);
        w_ord_ok   = (32'(i_item.order) < faf_pkg::ORDERS);
        w_in_set   = {i_item.mult_bin, i_item.zvertex_bin, i_item.harmonic, i_item.detector};
        w_is_load  = w_in_acc && w_in_range && w_ord_ok;
        w_cos_we   = (r_state == S_CLEAR) ||
                     (w_is_load && i_item.kind == faf_pkg::KIND_LOAD_COS);
        w_sin_we   = (r_state == S_CLEAR) ||
                     (w_is_load && i_item.kind == faf_pkg::KIND_LOAD_SIN);
        w_wr_addr  = (r_state == S_CLEAR) ? r_clr_addr : {w_in_set, i_item.order};
        w_wr_data  = (r_state == S_CLEAR) ? '0 : i_item.coefficient;
        w_rd_addr  = {r_set, r_k};

        // psi0 = n * psi, wrapped to one turn
        w_n    = 3'(i_item.harmonic) + 3'd1;
        w_prod = 19'(i_item.angle_in) * 19'(w_n);

        w_acc_mag = r_acc[faf_pkg::ACC_W-1] ? 35'(-r_acc) : 35'(r_acc);
        w_sum     = {r_ph, 18'd0} + 61'(r_pl);
        w_dmag    = w_sum[60:faf_pkg::BA_SHIFT];
        w_delta   = r_acc_n ? 16'(-w_dmag) : 16'(w_dmag);

        // Divide the wrapped total by n, truncating toward zero
        w_tmag = r_total[15] ? (17'h10000 - 17'(r_total)) : 17'(r_total);
        w_t3   = w_tmag * faf_pkg::DIV3_M;
        unique case (r_har)
            2'd0:    w_q = w_tmag;
            2'd1:    w_q = w_tmag >> 1;
            2'd2:    w_q = 17'(w_t3 >> faf_pkg::DIV3_SH);
            default: w_q = w_tmag >> 2;
        endcase

        w_req.valid = r_rd_vld;
        w_req.ang   = r_rd_ang;
        w_req.k_idx = r_rd_k;
        w_req.c     = r_rd_ok ? r_cos_rd : '0;
        w_req.s     = r_rd_ok ? r_sin_rd : '0;
    end

    // Memories: one write port (clear sweep or load), one registered read port
    always_ff @(posedge i_clk) begin
        if (w_cos_we) r_cos_mem[w_wr_addr] <= w_wr_data;
        if (w_sin_we) r_sin_mem[w_wr_addr] <= w_wr_data;
        r_cos_rd <= r_cos_mem[w_rd_addr];
        r_sin_rd <= r_sin_mem[w_rd_addr];
    end

    faf_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            // Drop the result word once the sink takes it; S_OUT decides on its own
            if (o_result.ready && r_state != S_OUT) r_out_valid <= 1'b0;

            // Fold each finished term into the radian accumulator
            if (w_rsp.valid) r_acc <= r_acc + faf_pkg::ACC_W'(w_rsp.term);

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == faf_pkg::ADDR_W'(faf_pkg::DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc && i_item.kind == faf_pkg::KIND_FLATTEN) begin
                        r_set    <= w_in_set;
                        r_set_ok <= w_in_range;
                        r_har    <= i_item.harmonic;
                        r_psi0   <= w_prod[15:0];
                        r_ang    <= w_prod[15:0];
                        r_k      <= '0;
                        r_acc    <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    // Issue one coefficient pair read per order; advance k*psi0
                    r_rd_vld <= 1'b1;
                    r_rd_ang <= r_ang;
                    r_rd_k   <= r_k;
                    r_rd_ok  <= r_set_ok;
                    r_ang    <= r_ang + r_psi0;
                    r_k      <= r_k + 1'b1;
                    if (r_k == faf_pkg::ORD_W'(faf_pkg::ORDERS - 1)) r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.valid && w_rsp.k_idx == faf_pkg::ORD_W'(faf_pkg::ORDERS - 1))
                        r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_ph    <= w_acc_mag[34:18] * faf_pkg::RAD_TO_BA;
                    r_pl    <= w_acc_mag[17:0] * faf_pkg::RAD_TO_BA;
                    r_acc_n <= r_acc[faf_pkg::ACC_W-1];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_total <= r_psi0 + w_delta;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_res   <= r_total[15] ? 16'(-w_q) : 16'(w_q);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_angle <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.angle_out = r_out_angle;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_item.ready)
        else $error("item accepted during clear sweep");
    a_flatten_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_item.kind == faf_pkg::KIND_FLATTEN) |=> (r_state == S_RUN))
        else $error("flatten word did not start the read sweep");
    a_term_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == S_RUN || r_state == S_WAIT))
        else $error("term arrived outside a flatten");
    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cos_we || w_sin_we) |-> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("memory written during a flatten");
    a_result_leaves_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result word not posted");
`endif

endmodule
